### rtl/core/bba_pkg.sv
// bba_pkg: sizes, types and the saturating add for balanced_bin_assigner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

	localparam int MAX_BINS    = 16;
	localparam int LOAD_BITS   = 48;
	localparam int LEN_W       = 32;
	localparam int NSPLIT_W    = 5;
	localparam int IDX_W       = $clog2(MAX_BINS);
	localparam int CNT_W       = $clog2(MAX_BINS + 1);
	localparam int SUM_W       = LOAD_BITS + IDX_W;
	localparam int PROD_W      = LOAD_BITS + CNT_W;
	localparam int DEV_W       = PROD_W + IDX_W;
	localparam int IN_TDATA_W  = ((LEN_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = IDX_W + LOAD_BITS + 2;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

	typedef logic [LOAD_BITS-1:0] load_t;

	typedef struct packed {
		logic  clip;
		load_t load;
	} sat_res_t;

	// load plus length, held at the top of the range
	function automatic sat_res_t sat_add(input load_t a, input logic [LEN_W-1:0] len);
		logic [LOAD_BITS:0] s;
		sat_res_t           r;
		s = {1'b0, a} + (LOAD_BITS + 1)'(len);
		if (s[LOAD_BITS]) begin
			r.clip = 1'b1;
			r.load = LOAD_MAX;
		end else begin
			r.clip = 1'b0;
			r.load = s[LOAD_BITS-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/balanced_bin_assigner.sv
// balanced_bin_assigner: greedy bin choice by least sum of absolute deviations
// depends on bba_pkg
//
// usage: one transaction on s_axis carries an interval length; one transaction
// on m_axis returns the chosen bin, its new load and two flags. cfg_we writes
// the bin count (0 acts as 1, above MAX_BINS acts as MAX_BINS); the user must
// do so only while the block is idle, as the block itself does not enforce it.
// while fewer bins are open than the bin count, an item opens the next bin; that
// result, like any with one bin, needs no sweep and goes from ST_UPDATE to the output register.
// otherwise, with n open bins, one shared datapath (a read mux, a load-by-n
// multiplier, an absolute difference and accumulators) sweeps the bins: one
// pass for the total, then n trials, one per open bin, each scoring all n bins.
// s_axis_tready is high only when the block is idle; the result waits in an
// output register, so the next item can be accepted before it is taken. if the
// receiver stalls and a second result is done, the block holds until the first
// is taken. reset clears all bin loads, closes all bins and sets the bin count to 1.
`timescale 1ns / 1ps
`default_nettype none

module balanced_bin_assigner
	import bba_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_we,
	input  wire [NSPLIT_W-1:0]     cfg_wdata,      // bin count
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_TDATA_W-1:0]   s_axis_tdata,   // item_length
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // bin_index, bin_load, opened_bin, load_saturated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TOTAL,
		ST_PREP,
		ST_TSET,
		ST_SCORE,
		ST_CMP,
		ST_UPDATE
	} state_t;

	state_t               state_q;
	logic [NSPLIT_W-1:0]  split_q;
	load_t                bin_q [MAX_BINS];
	logic [CNT_W-1:0]     bins_q;
	logic [LEN_W-1:0]     len_q;
	logic [CNT_W-1:0]     iss_q;
	logic [CNT_W-1:0]     t_q;
	logic [IDX_W-1:0]     idx_q;
	logic                 opened_q;
	logic [SUM_W-1:0]     tot_q;
	logic [SUM_W-1:0]     ttot_q;
	load_t                cand_q;
	logic [DEV_W-1:0]     dev_q;
	logic [DEV_W-1:0]     best_q;

	logic                 v_s1, v_s2, v_s3;
	load_t                val_s1;
	logic [PROD_W-1:0]    prod_s2;
	logic [PROD_W-1:0]    absd_s3;

	logic                 out_v_q;
	logic [IDX_W-1:0]     out_idx_q;
	load_t                out_load_q;
	logic                 out_open_q;
	logic                 out_clip_q;

	logic [CNT_W-1:0]     eff;
	logic [IDX_W-1:0]     rd_addr;
	load_t                rd_data;
	sat_res_t             sat_rd;
	logic                 issue;
	logic [PROD_W-1:0]    ttot_ext;

	// effective bin count
	always_comb begin
		if (split_q == '0) begin
			eff = CNT_W'(1);
		end else if (32'(split_q) > 32'(MAX_BINS)) begin
			eff = CNT_W'(MAX_BINS);
		end else begin
			eff = CNT_W'(split_q);
		end
	end

	// single shared read port
	always_comb begin
		case (state_q)
			ST_PREP:   rd_addr = t_q[IDX_W-1:0];
			ST_UPDATE: rd_addr = idx_q;
			default:   rd_addr = iss_q[IDX_W-1:0];
		endcase
	end

	assign rd_data  = bin_q[rd_addr];
	assign sat_rd   = sat_add(rd_data, len_q);
	assign issue    = (state_q == ST_TOTAL || state_q == ST_SCORE) && (iss_q < bins_q);
	assign ttot_ext = PROD_W'(ttot_q);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - OUT_FIELD_W)'(0), out_clip_q, out_open_q,
		out_load_q, out_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			split_q     <= NSPLIT_W'(1);
			for (int i = 0; i < MAX_BINS; i++) begin
				bin_q[i] <= '0;
			end
			bins_q      <= '0;
			len_q       <= '0;
			iss_q       <= '0;
			t_q         <= '0;
			idx_q       <= '0;
			opened_q    <= 1'b0;
			tot_q       <= '0;
			ttot_q      <= '0;
			cand_q      <= '0;
			dev_q       <= '0;
			best_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			val_s1      <= '0;
			prod_s2     <= '0;
			absd_s3     <= '0;
			out_v_q     <= 1'b0;
			out_idx_q   <= '0;
			out_load_q  <= '0;
			out_open_q  <= 1'b0;
			out_clip_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				split_q <= cfg_wdata;
			end
			if (out_v_q && m_axis_tready && state_q != ST_UPDATE) begin
				out_v_q <= 1'b0;
			end

			// sweep pipeline: read, multiply by n, absolute difference
			v_s1 <= issue;
			if (issue) begin
				val_s1 <= (state_q == ST_SCORE && iss_q == t_q) ? cand_q : rd_data;
				iss_q  <= iss_q + CNT_W'(1);
			end
			v_s2    <= v_s1 && (state_q == ST_SCORE);
			prod_s2 <= PROD_W'(val_s1) * PROD_W'(bins_q);
			v_s3    <= v_s2;
			absd_s3 <= (prod_s2 >= ttot_ext) ? (prod_s2 - ttot_ext) : (ttot_ext - prod_s2);

			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						len_q <= s_axis_tdata[LEN_W-1:0];
						iss_q <= '0;
						tot_q <= '0;
						if (bins_q < eff) begin
							idx_q    <= bins_q[IDX_W-1:0];
							opened_q <= 1'b1;
							bins_q   <= bins_q + CNT_W'(1);
							state_q  <= ST_UPDATE;
						end else if (eff == CNT_W'(1)) begin
							idx_q    <= '0;
							opened_q <= 1'b0;
							state_q  <= ST_UPDATE;
						end else begin
							opened_q <= 1'b0;
							state_q  <= ST_TOTAL;
						end
					end
				end
				ST_TOTAL: begin
					if (v_s1) begin
						tot_q <= tot_q + SUM_W'(val_s1);
					end
					if (!issue && !v_s1) begin
						t_q     <= '0;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cand_q  <= sat_rd.load;
					ttot_q  <= tot_q - SUM_W'(rd_data);
					state_q <= ST_TSET;
				end
				ST_TSET: begin
					ttot_q  <= ttot_q + SUM_W'(cand_q);
					iss_q   <= '0;
					dev_q   <= '0;
					state_q <= ST_SCORE;
				end
				ST_SCORE: begin
					if (v_s3) begin
						dev_q <= dev_q + DEV_W'(absd_s3);
					end
					if (!issue && !v_s1 && !v_s2 && !v_s3) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (t_q == '0 || dev_q < best_q) begin
						best_q <= dev_q;
						idx_q  <= t_q[IDX_W-1:0];
					end
					if (t_q + CNT_W'(1) == bins_q) begin
						state_q <= ST_UPDATE;
					end else begin
						t_q     <= t_q + CNT_W'(1);
						state_q <= ST_PREP;
					end
				end
				ST_UPDATE: begin
					if (!out_v_q || m_axis_tready) begin
						bin_q[idx_q] <= sat_rd.load;
						out_v_q      <= 1'b1;
						out_idx_q    <= idx_q;
						out_load_q   <= sat_rd.load;
						out_open_q   <= opened_q;
						out_clip_q   <= sat_rd.clip;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### bench/tb_top.sv
// tb_top: self-checking bench for balanced_bin_assigner, with a scoreboard class that
// predicts the bin, load and flags of every transaction; random stalls on both streams
// depends on bba_pkg and balanced_bin_assigner
`timescale 1ns / 1ps

module tb_top;
	import bba_pkg::*;

	// packed so that the low bits line up with m_axis_tdata
	typedef struct packed {
		logic             clip;
		logic             opened;
		load_t            load;
		logic [IDX_W-1:0] bin;
	} placement_t;

	class bin_scoreboard;
		load_t               bin_load_of [MAX_BINS];
		int unsigned         open_bins;
		logic [NSPLIT_W-1:0] split_cfg;
		placement_t          due [$];
		int unsigned         errors, checked, lengths, openings, trials, clips;

		function new();
			foreach (bin_load_of[i])
				bin_load_of[i] = '0;
			open_bins = 0;
			split_cfg = 1;
			errors    = 0;
			checked   = 0;
			lengths   = 0;
			openings  = 0;
			trials    = 0;
			clips     = 0;
		endfunction

		function load_t add_clipped(input load_t a, input logic [LEN_W-1:0] len,
				output logic clip);
			clip = (LOAD_BITS'(len) > (LOAD_MAX - a));
			return clip ? LOAD_MAX : a + LOAD_BITS'(len);
		endfunction

		// n times the summed absolute deviation, bin t holding cand
		function logic [63:0] spread_score(input int unsigned n, input int unsigned t,
				input load_t cand);
			logic [63:0] total, dev, v;
			int unsigned i;
			total = '0;
			dev   = '0;
			for (i = 0; i < n; i++)
				total += 64'(i == t ? cand : bin_load_of[i]);
			for (i = 0; i < n; i++) begin
				v = 64'(n) * 64'(i == t ? cand : bin_load_of[i]);
				dev += (v < total) ? total - v : v - total;
			end
			return dev;
		endfunction

		function void note_length(input logic [LEN_W-1:0] len);
			int unsigned eff, t, idx;
			logic [63:0] best, score;
			logic        c;
			placement_t  p;
			eff = (split_cfg == 0) ? 1 : ((split_cfg > MAX_BINS) ? MAX_BINS : split_cfg);
			idx      = 0;
			best     = '0;
			p.opened = 1'b0;
			if (open_bins < eff) begin
				idx = open_bins;
				open_bins++;
				p.opened = 1'b1;
				openings++;
			end else if (eff > 1) begin
				trials++;
				for (t = 0; t < open_bins; t++) begin
					score = spread_score(open_bins, t, add_clipped(bin_load_of[t], len, c));
					if (t == 0 || score < best) begin
						best = score;
						idx  = t;
					end
				end
			end
			p.load = add_clipped(bin_load_of[idx], len, c);
			p.clip = c;
			p.bin  = idx[IDX_W-1:0];
			bin_load_of[idx] = p.load;
			if (c)
				clips++;
			lengths++;
			due = {due, p};
		endfunction

		task report(input string what, input logic [63:0] got, input logic [63:0] want);
			if (errors < 30)
				$display("[%0t] result %0d: %s is %0h, expected %0h", $time, checked, what,
					got, want);
			errors++;
		endtask

		task check_result(input logic [OUT_TDATA_W-1:0] word);
			placement_t got, want;
			got = word[OUT_FIELD_W-1:0];
			checked++;
			if (due.size() == 0) begin
				report("transaction with nothing awaited, tdata", 64'(word), 64'd0);
				return;
			end
			want = due.pop_front();
			if (got.bin != want.bin)
				report("bin_index", 64'(got.bin), 64'(want.bin));
			if (got.load != want.load)
				report("bin_load", 64'(got.load), 64'(want.load));
			if (got.opened != want.opened)
				report("opened_bin", 64'(got.opened), 64'(want.opened));
			if (got.clip != want.clip)
				report("load_saturated", 64'(got.clip), 64'(want.clip));
			if (word[OUT_TDATA_W-1:OUT_FIELD_W] != '0)
				report("tdata padding", 64'(word[OUT_TDATA_W-1:OUT_FIELD_W]), 64'd0);
		endtask
	endclass

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [NSPLIT_W-1:0]    cfg_wdata     = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	bit                     calm          = 1'b0;
	bin_scoreboard          sb            = new();
	int                     splits [10]   = '{4, 2, 7, 1, 11, 0, 16, 5, 31, 3};

	balanced_bin_assigner uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
	end

	// receiver: random stall bursts, one long hold once the stream is going
	initial begin
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && sb.checked >= 40) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(negedge clk);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 18) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2:    return LEN_W'($urandom_range(0, 15));
			3:       return {LEN_W{1'b1}} - LEN_W'($urandom_range(0, 3));
			4:       return LEN_W'(1) << $urandom_range(0, LEN_W - 1);
			default: return LEN_W'($urandom());
		endcase
	endfunction

	task automatic send_length(input logic [LEN_W-1:0] len);
		@(negedge clk);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= len;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_length(len);
	endtask

	// stop offering and wait until every awaited result is in
	task automatic settle(input int unsigned extra);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.due.size() != 0)
			@(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_split(input logic [NSPLIT_W-1:0] value);
		settle(4);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.split_cfg = value;
	endtask

	initial begin
		#60_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// single bin, then zero count, then opening and trials
		send_length('0);
		send_length({LEN_W{1'b1}});
		write_split(0);
		send_length(5);
		write_split(3);
		send_length(32'h5555_5555);
		send_length(32'hAAAA_AAAA);
		send_length('0);
		send_length(1);
		send_length(32'h8000_0000);
		send_length(7);
		// count lowered below the open bins
		write_split(2);
		send_length(3);
		send_length('0);
		write_split(1);
		send_length(9);

		foreach (splits[k]) begin
			if (k == $size(splits) - 1)
				calm = 1'b1;
			write_split(NSPLIT_W'(splits[k]));
			repeat (110) send_length(pick_length());
		end

		// single bin with the longest length, then trials at the full count
		write_split(1);
		send_length({LEN_W{1'b1}});
		send_length('0);
		send_length(1);
		write_split(16);
		repeat (20) send_length(pick_length());

		settle(20);
		$display("covered %0d lengths, split settings 0 to 31, %0d opened a bin, %0d trials",
			sb.lengths, sb.openings, sb.trials);
		$display("%0d clipped loads, %0d results checked, %0d mismatches",
			sb.clips, sb.checked, sb.errors);
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
